// ----- sv/scr_pkg.sv -----
// Shared constants, op codes and a helper function for the seam carving resizer.
// No dependencies; used by scr_isqrt, seam_carving_resizer_top and tb_top.
`timescale 1ns / 1ps
package scr_pkg;
	// default image limits
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	// field widths
	localparam int PIX_W  = 24;
	localparam int GAP_W  = 10;
	localparam int SQ_W   = 32;
	localparam int ROOT_W = 16;
	localparam int SQ_STEPS = 16;

	// operation codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_CARVE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_SRC_W = 2'd0;
	localparam logic [1:0] REG_SRC_H = 2'd1;
	localparam logic [1:0] REG_TGT_W = 2'd2;
	localparam logic [1:0] REG_TGT_H = 2'd3;

	// sum of absolute channel differences between two RGB pixels
	function automatic logic [GAP_W-1:0] colour_gap(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		logic [7:0] dr, dg, db;
		dr = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
		dg = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
		db = (a[7:0] > b[7:0]) ? a[7:0] - b[7:0] : b[7:0] - a[7:0];
		return GAP_W'(dr) + GAP_W'(dg) + GAP_W'(db);
	endfunction
endpackage

// ----- sv/scr_isqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
// Depends on scr_pkg.
`timescale 1ns / 1ps
module scr_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [scr_pkg::SQ_W-1:0]   radicand,
	output logic                       done,
	output logic [scr_pkg::ROOT_W-1:0] root
);
	import scr_pkg::*;

	logic [SQ_W-1:0] x_q, res_q, bit_q;
	logic [4:0]      cnt_q;
	logic            busy_q, done_q;
	logic [SQ_W-1:0] trial;

	assign trial = res_q + bit_q;

	// one restoring step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			x_q    <= '0;
			res_q  <= '0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q    <= radicand;
				res_q  <= '0;
				bit_q  <= SQ_W'(1) << (SQ_W - 2);
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (x_q >= trial) begin
					x_q   <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(SQ_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];
endmodule

// ----- sv/seam_carving_resizer_top.sv -----
// Seam carving resizer: pixel, cost and seam stores with a sequencer over them.
// Depends on scr_pkg and scr_isqrt.
`timescale 1ns / 1ps
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tuser: operation; tdata: row, col, red, green, blue
//  m_*     | out | m_tvalid/m_tready  | tuser: status; tdata: rgb out, current size
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
// Write and read requests pass through ST_RDW and ST_FIN and may wait at the output.
// A carve request runs per seam: energy per cell (the serial square root dominates),
// cost accumulation per cell, a minimum search over the last line, backtrack per
// line and a shift per moved pixel, all bound by the single read port of each store.
// Reset sets sizes and targets to 256; stores have no clearing pass.
// Input is not ready while a request runs, also while its result waits for the output.
module seam_carving_resizer_top #(
	parameter int MAX_WIDTH  = scr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = scr_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // [1:0] operation
	input  logic [39:0] s_tdata,   // row, col, red, green, blue
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [0:0]  m_tuser,   // [0] status
	output logic [47:0] m_tdata,   // red_out, green_out, blue_out, current_width, current_height
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	import scr_pkg::*;

	localparam int MAXD   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int RW     = $clog2(MAX_HEIGHT);
	localparam int AW     = RW + CW;
	localparam int IW     = $clog2(MAXD);
	localparam int SZ     = $clog2(MAXD + 1);
	localparam int COST_W = ROOT_W + IW;

	typedef enum logic [25:0] {
		ST_IDLE = 26'd1 << 0,  ST_RDW = 26'd1 << 1,  ST_FIN = 26'd1 << 2,
		ST_CHK  = 26'd1 << 3,  ST_EA  = 26'd1 << 4,  ST_EB  = 26'd1 << 5,
		ST_EC   = 26'd1 << 6,  ST_ED  = 26'd1 << 7,  ST_EE  = 26'd1 << 8,
		ST_EF   = 26'd1 << 9,  ST_ESQ = 26'd1 << 10, ST_AR0 = 26'd1 << 11,
		ST_AR1  = 26'd1 << 12, ST_AR2 = 26'd1 << 13, ST_AR3 = 26'd1 << 14,
		ST_AW   = 26'd1 << 15, ST_FMA = 26'd1 << 16, ST_FMB = 26'd1 << 17,
		ST_BT0  = 26'd1 << 18, ST_BT1 = 26'd1 << 19, ST_BT2 = 26'd1 << 20,
		ST_BT3  = 26'd1 << 21, ST_SHS = 26'd1 << 22, ST_SHL = 26'd1 << 23,
		ST_SHR  = 26'd1 << 24, ST_SHW = 26'd1 << 25
	} state_t;

	// size held within [2, most]
	function automatic logic [SZ-1:0] hold_size(input logic [8:0] v, input int most);
		if (v < 9'd2) return SZ'(2);
		if (int'(v) > most) return SZ'(most);
		return SZ'(v);
	endfunction

	// store address of (line, position); dir 0 means lines are rows
	function automatic logic [AW-1:0] at(input logic d, input logic [SZ-1:0] l,
			input logic [SZ-1:0] p);
		if (!d) return {l[RW-1:0], p[CW-1:0]};
		return {p[RW-1:0], l[CW-1:0]};
	endfunction

	// backtrack step: inward on an edge tie, lowest index in the middle
	function automatic logic [SZ-1:0] pick(input logic [SZ-1:0] idx,
			input logic [SZ-1:0] last, input logic [COST_W-1:0] vm,
			input logic [COST_W-1:0] v0, input logic [COST_W-1:0] vp);
		logic [SZ-1:0]     best;
		logic [COST_W-1:0] bv;
		if (idx == '0) return (v0 < vp) ? SZ'(0) : SZ'(1);
		if (idx == last) return (v0 < vm) ? idx : idx - SZ'(1);
		best = idx - SZ'(1);
		bv   = vm;
		if (v0 < bv) begin
			best = idx;
			bv   = v0;
		end
		if (vp < bv) best = idx + SZ'(1);
		return best;
	endfunction

	state_t            state_q;
	logic              dir_q;
	logic [SZ-1:0]     w_q, h_q, l_q, p_q, idx_q;
	logic [8:0]        tw_q, th_q;
	logic [COST_W-1:0] best_q, bv_q, vm_q, v0_q;
	logic [PIX_W-1:0]  pa_q, rgb_q;
	logic [GAP_W-1:0]  g1_q, g2_q;
	logic [2*GAP_W-1:0] sq_q;
	logic              status_q, rd_ok_q, mv_q, m_status_q;
	logic [47:0]       m_data_q;

	// stores
	logic [PIX_W-1:0]  pix_mem [2**AW];
	logic [COST_W-1:0] cost_mem [2**AW];
	logic [IW-1:0]     seam_mem [2**IW];
	logic [PIX_W-1:0]  pix_rd_q;
	logic [COST_W-1:0] cost_rd_q;
	logic [IW-1:0]     seam_rd_q;

	logic              pix_we, cost_we, seam_we;
	logic [AW-1:0]     pix_ra, pix_wa, cost_ra, cost_wa;
	logic [PIX_W-1:0]  pix_wd;
	logic [COST_W-1:0] cost_wd;
	logic [IW-1:0]     seam_wa, seam_ra, seam_wd;

	logic [SZ-1:0]     len_l, len_p, lf, rt, up, dn, nidx, bidx;
	logic              accept, oor, fm_take;
	logic [1:0]        op_in;
	logic [7:0]        row_in, col_in;
	logic [AW-1:0]     io_addr;
	logic [2*GAP_W:0]  sum_sq;
	logic              sq_start, sq_done;
	logic [ROOT_W-1:0] sq_root;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign op_in  = s_tuser;
	assign row_in = s_tdata[7:0];
	assign col_in = s_tdata[15:8];
	assign io_addr = {RW'(row_in), CW'(col_in)};
	assign oor = (32'(row_in) >= 32'(h_q)) || (32'(col_in) >= 32'(w_q));

	// line count and positions per line for the current seam direction
	assign len_l = dir_q ? w_q : h_q;
	assign len_p = dir_q ? h_q : w_q;
	assign lf = (p_q == '0) ? len_p - SZ'(1) : p_q - SZ'(1);
	assign rt = (p_q + SZ'(1) == len_p) ? '0 : p_q + SZ'(1);
	assign up = (l_q == '0) ? len_l - SZ'(1) : l_q - SZ'(1);
	assign dn = (l_q + SZ'(1) == len_l) ? '0 : l_q + SZ'(1);
	assign fm_take = (p_q == '0) || (cost_rd_q < bv_q);
	assign nidx = fm_take ? p_q : idx_q;
	assign bidx = pick(idx_q, len_p - SZ'(1), vm_q, v0_q, cost_rd_q);
	assign sum_sq = (2*GAP_W+1)'(sq_q) + (2*GAP_W+1)'(g2_q) * (2*GAP_W+1)'(g2_q);
	assign sq_start = (state_q == ST_EF);

	scr_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (SQ_W'({sum_sq, 8'h00})),
		.done     (sq_done),
		.root     (sq_root)
	);

	// store port selection
	always_comb begin
		pix_we  = 1'b0;
		pix_wa  = at(dir_q, l_q, p_q);
		pix_wd  = pix_rd_q;
		pix_ra  = at(dir_q, l_q, p_q);
		cost_we = 1'b0;
		cost_wa = at(dir_q, l_q, p_q);
		cost_wd = cost_rd_q + best_q;
		cost_ra = at(dir_q, l_q, p_q);
		seam_we = 1'b0;
		seam_wa = l_q[IW-1:0];
		seam_wd = nidx[IW-1:0];
		seam_ra = l_q[IW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				pix_ra = io_addr;
				pix_wa = io_addr;
				pix_wd = s_tdata[39:16];
				pix_we = accept && (op_in == OP_WRITE) && !oor;
			end
			ST_EA: pix_ra = at(dir_q, l_q, lf);
			ST_EB: pix_ra = at(dir_q, l_q, rt);
			ST_EC: pix_ra = at(dir_q, up, p_q);
			ST_ED: pix_ra = at(dir_q, dn, p_q);
			ST_ESQ: begin
				cost_we = sq_done;
				cost_wd = COST_W'(sq_root);
			end
			ST_AR0: cost_ra = at(dir_q, l_q - SZ'(1), p_q);
			ST_AR1: cost_ra = at(dir_q, l_q - SZ'(1), (p_q == '0) ? p_q : p_q - SZ'(1));
			ST_AR2: cost_ra = at(dir_q, l_q - SZ'(1),
					(p_q + SZ'(1) == len_p) ? p_q : p_q + SZ'(1));
			ST_AR3: cost_ra = at(dir_q, l_q, p_q);
			ST_AW:  cost_we = 1'b1;
			ST_FMA: cost_ra = at(dir_q, len_l - SZ'(1), p_q);
			ST_FMB: begin
				seam_we = (p_q + SZ'(1) == len_p);
				seam_wa = IW'(len_l - SZ'(1));
			end
			ST_BT0: cost_ra = at(dir_q, l_q - SZ'(1),
					(idx_q == '0) ? idx_q : idx_q - SZ'(1));
			ST_BT1: cost_ra = at(dir_q, l_q - SZ'(1), idx_q);
			ST_BT2: cost_ra = at(dir_q, l_q - SZ'(1),
					(idx_q + SZ'(1) == len_p) ? idx_q : idx_q + SZ'(1));
			ST_BT3: begin
				seam_we = 1'b1;
				seam_wa = IW'(l_q - SZ'(1));
				seam_wd = bidx[IW-1:0];
			end
			ST_SHR: pix_ra = at(dir_q, l_q, p_q + SZ'(1));
			ST_SHW: pix_we = 1'b1;
			default: ;
		endcase
	end

	// memories with registered reads
	always_ff @(posedge clk) begin
		if (pix_we) pix_mem[pix_wa] <= pix_wd;
		pix_rd_q <= pix_mem[pix_ra];
	end

	always_ff @(posedge clk) begin
		if (cost_we) cost_mem[cost_wa] <= cost_wd;
		cost_rd_q <= cost_mem[cost_ra];
	end

	always_ff @(posedge clk) begin
		if (seam_we) seam_mem[seam_wa] <= seam_wd;
		seam_rd_q <= seam_mem[seam_ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			dir_q      <= 1'b0;
			w_q        <= hold_size(9'd256, MAX_WIDTH);
			h_q        <= hold_size(9'd256, MAX_HEIGHT);
			tw_q       <= 9'd256;
			th_q       <= 9'd256;
			l_q        <= '0;
			p_q        <= '0;
			idx_q      <= '0;
			best_q     <= '0;
			bv_q       <= '0;
			vm_q       <= '0;
			v0_q       <= '0;
			pa_q       <= '0;
			rgb_q      <= '0;
			g1_q       <= '0;
			g2_q       <= '0;
			sq_q       <= '0;
			status_q   <= 1'b0;
			rd_ok_q    <= 1'b0;
			mv_q       <= 1'b0;
			m_status_q <= 1'b0;
			m_data_q   <= '0;
		end else begin
			if (mv_q && m_tready) mv_q <= 1'b0;

			// register writes
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SRC_W: w_q <= hold_size(cfg_data, MAX_WIDTH);
					REG_SRC_H: h_q <= hold_size(cfg_data, MAX_HEIGHT);
					REG_TGT_W: tw_q <= cfg_data;
					REG_TGT_H: th_q <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rgb_q    <= '0;
						status_q <= ((op_in == OP_WRITE) || (op_in == OP_READ)) && oor;
						rd_ok_q  <= (op_in == OP_READ) && !oor;
						state_q  <= (op_in == OP_CARVE) ? ST_CHK : ST_RDW;
					end
				end
				ST_RDW: begin
					if (rd_ok_q) rgb_q <= pix_rd_q;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// stored pixel holds red in the low byte
					if (!mv_q || m_tready) begin
						mv_q       <= 1'b1;
						m_status_q <= status_q;
						m_data_q   <= {6'd0, 9'(h_q), 9'(w_q),
								rgb_q[23:16], rgb_q[15:8], rgb_q[7:0]};
						state_q    <= ST_IDLE;
					end
				end
				ST_CHK: begin
					l_q <= '0;
					p_q <= '0;
					if (32'(w_q) > ((tw_q < 9'd2) ? 32'd2 : 32'(tw_q))) begin
						dir_q   <= 1'b0;
						state_q <= ST_EA;
					end else if (32'(h_q) > ((th_q < 9'd2) ? 32'd2 : 32'(th_q))) begin
						dir_q   <= 1'b1;
						state_q <= ST_EA;
					end else begin
						state_q <= ST_FIN;
					end
				end
				// energy of one cell
				ST_EA: state_q <= ST_EB;
				ST_EB: begin
					pa_q    <= pix_rd_q;
					state_q <= ST_EC;
				end
				ST_EC: begin
					g1_q    <= colour_gap(pa_q, pix_rd_q);
					state_q <= ST_ED;
				end
				ST_ED: begin
					pa_q    <= pix_rd_q;
					sq_q    <= g1_q * g1_q;
					state_q <= ST_EE;
				end
				ST_EE: begin
					g2_q    <= colour_gap(pa_q, pix_rd_q);
					state_q <= ST_EF;
				end
				ST_EF: state_q <= ST_ESQ;
				ST_ESQ: begin
					if (sq_done) begin
						if (p_q + SZ'(1) == len_p) begin
							p_q <= '0;
							if (l_q + SZ'(1) == len_l) begin
								l_q     <= SZ'(1);
								state_q <= ST_AR0;
							end else begin
								l_q     <= l_q + SZ'(1);
								state_q <= ST_EA;
							end
						end else begin
							p_q     <= p_q + SZ'(1);
							state_q <= ST_EA;
						end
					end
				end
				// cost accumulation over three predecessors
				ST_AR0: state_q <= ST_AR1;
				ST_AR1: begin
					best_q  <= cost_rd_q;
					state_q <= ST_AR2;
				end
				ST_AR2: begin
					if (cost_rd_q < best_q) best_q <= cost_rd_q;
					state_q <= ST_AR3;
				end
				ST_AR3: begin
					if (cost_rd_q < best_q) best_q <= cost_rd_q;
					state_q <= ST_AW;
				end
				ST_AW: begin
					if (p_q + SZ'(1) == len_p) begin
						p_q <= '0;
						if (l_q + SZ'(1) == len_l) begin
							state_q <= ST_FMA;
						end else begin
							l_q     <= l_q + SZ'(1);
							state_q <= ST_AR0;
						end
					end else begin
						p_q     <= p_q + SZ'(1);
						state_q <= ST_AR0;
					end
				end
				// minimum of the last line, lowest index on ties
				ST_FMA: state_q <= ST_FMB;
				ST_FMB: begin
					if (fm_take) bv_q <= cost_rd_q;
					idx_q <= nidx;
					if (p_q + SZ'(1) == len_p) begin
						l_q     <= len_l - SZ'(1);
						state_q <= ST_BT0;
					end else begin
						p_q     <= p_q + SZ'(1);
						state_q <= ST_FMA;
					end
				end
				// backtrack one line
				ST_BT0: state_q <= ST_BT1;
				ST_BT1: begin
					vm_q    <= cost_rd_q;
					state_q <= ST_BT2;
				end
				ST_BT2: begin
					v0_q    <= cost_rd_q;
					state_q <= ST_BT3;
				end
				ST_BT3: begin
					idx_q <= bidx;
					if (l_q == SZ'(1)) begin
						l_q     <= '0;
						state_q <= ST_SHS;
					end else begin
						l_q     <= l_q - SZ'(1);
						state_q <= ST_BT0;
					end
				end
				// close the gap left by the seam
				ST_SHS: state_q <= ST_SHL;
				ST_SHL: begin
					p_q     <= SZ'(seam_rd_q);
					state_q <= ST_SHR;
				end
				ST_SHR: begin
					if (p_q + SZ'(1) < len_p) begin
						state_q <= ST_SHW;
					end else if (l_q + SZ'(1) == len_l) begin
						if (dir_q) h_q <= h_q - SZ'(1);
						else w_q <= w_q - SZ'(1);
						state_q <= ST_CHK;
					end else begin
						l_q     <= l_q + SZ'(1);
						state_q <= ST_SHS;
					end
				end
				ST_SHW: begin
					p_q     <= p_q + SZ'(1);
					state_q <= ST_SHR;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = mv_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = m_data_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != ST_IDLE))
		else $error("input accepted while sequencer stayed idle");
	a_shift_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHW) |-> (p_q + SZ'(1) < len_p))
		else $error("shift past end of line");
	a_seam_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BT3) |=> (idx_q < len_p))
		else $error("seam index outside line");
	a_size_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(w_q >= SZ'(2)) && (h_q >= SZ'(2)))
		else $error("image size below two");
`endif
endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for seam_carving_resizer_top: a scoreboard class predicts
// every result from accepted write, read, carve and unused-code requests. Depends on scr_pkg.
`timescale 1ns / 1ps
module tb_top;
	import scr_pkg::*;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       status;
		logic [8:0] width;
		logic [8:0] height;
	} pix_result_t;

	// Image predictor plus queue of expected results
	class pixel_scoreboard;
		logic [23:0]  pix_mem [65536];
		int unsigned  cost_mem [65536];
		int unsigned  seam_idx [256];
		int unsigned  w_now = 256, h_now = 256, tgt_w = 256, tgt_h = 256;
		pix_result_t  pending_q[$];
		int           errors = 0;
		int           seams = 0;
		int           checked = 0;

		function int unsigned clamp(int unsigned v, int unsigned most);
			if (v < 2) return 2;
			if (v > most) return most;
			return v;
		endfunction

		function void set_reg(logic [1:0] idx, logic [8:0] v);
			case (idx)
				REG_SRC_W: w_now = clamp(v, 256);
				REG_SRC_H: h_now = clamp(v, 256);
				REG_TGT_W: tgt_w = v;
				default:   tgt_h = v;
			endcase
		endfunction

		function int unsigned rgb_gap(logic [23:0] a, logic [23:0] b);
			int unsigned s;
			s = 0;
			for (int k = 0; k < 3; k++) begin
				if (a[k*8 +: 8] > b[k*8 +: 8]) s += a[k*8 +: 8] - b[k*8 +: 8];
				else s += b[k*8 +: 8] - a[k*8 +: 8];
			end
			return s;
		endfunction

		function int unsigned int_root(int unsigned x);
			longint unsigned res, t;
			res = 0;
			for (int b = 15; b >= 0; b--) begin
				t = res | (64'd1 << b);
				if (t * t <= x) res = t;
			end
			return int'(res);
		endfunction

		function int unsigned at(int unsigned r, int unsigned c);
			return r * 256 + c;
		endfunction

		function void fill_energy();
			int unsigned up, dn, lf, rt, dh, dv;
			for (int unsigned r = 0; r < h_now; r++) begin
				up = (r == 0) ? h_now - 1 : r - 1;
				dn = (r + 1 == h_now) ? 0 : r + 1;
				for (int unsigned c = 0; c < w_now; c++) begin
					lf = (c == 0) ? w_now - 1 : c - 1;
					rt = (c + 1 == w_now) ? 0 : c + 1;
					dh = rgb_gap(pix_mem[at(r, lf)], pix_mem[at(r, rt)]);
					dv = rgb_gap(pix_mem[at(up, c)], pix_mem[at(dn, c)]);
					cost_mem[at(r, c)] = int_root((dh * dh + dv * dv) << 8);
				end
			end
		endfunction

		// edge ties step inward, middle ties take the lowest index
		function int unsigned pick(int unsigned idx, int unsigned last, int unsigned vm,
				int unsigned v0, int unsigned vp);
			int unsigned best, bv;
			if (idx == 0) return (v0 < vp) ? 0 : 1;
			if (idx == last) return (v0 < vm) ? idx : idx - 1;
			best = idx - 1;
			bv = vm;
			if (v0 < bv) begin
				best = idx;
				bv = v0;
			end
			if (vp < bv) best = idx + 1;
			return best;
		endfunction

		function void cut_vertical();
			int unsigned best, idx, vm, vp;
			fill_energy();
			for (int unsigned r = 1; r < h_now; r++)
				for (int unsigned c = 0; c < w_now; c++) begin
					best = cost_mem[at(r - 1, c)];
					if (c > 0 && cost_mem[at(r - 1, c - 1)] < best) best = cost_mem[at(r - 1, c - 1)];
					if (c + 1 < w_now && cost_mem[at(r - 1, c + 1)] < best)
						best = cost_mem[at(r - 1, c + 1)];
					cost_mem[at(r, c)] += best;
				end
			idx = 0;
			for (int unsigned c = 1; c < w_now; c++)
				if (cost_mem[at(h_now - 1, c)] < cost_mem[at(h_now - 1, idx)]) idx = c;
			seam_idx[h_now - 1] = idx;
			for (int unsigned r = h_now - 1; r > 0; r--) begin
				vm = (idx > 0) ? cost_mem[at(r - 1, idx - 1)] : 0;
				vp = (idx + 1 < w_now) ? cost_mem[at(r - 1, idx + 1)] : 0;
				idx = pick(idx, w_now - 1, vm, cost_mem[at(r - 1, idx)], vp);
				seam_idx[r - 1] = idx;
			end
			for (int unsigned r = 0; r < h_now; r++)
				for (int unsigned c = seam_idx[r]; c + 1 < w_now; c++)
					pix_mem[at(r, c)] = pix_mem[at(r, c + 1)];
			w_now--;
			seams++;
		endfunction

		function void cut_horizontal();
			int unsigned best, idx, vm, vp;
			fill_energy();
			for (int unsigned c = 1; c < w_now; c++)
				for (int unsigned r = 0; r < h_now; r++) begin
					best = cost_mem[at(r, c - 1)];
					if (r > 0 && cost_mem[at(r - 1, c - 1)] < best) best = cost_mem[at(r - 1, c - 1)];
					if (r + 1 < h_now && cost_mem[at(r + 1, c - 1)] < best)
						best = cost_mem[at(r + 1, c - 1)];
					cost_mem[at(r, c)] += best;
				end
			idx = 0;
			for (int unsigned r = 1; r < h_now; r++)
				if (cost_mem[at(r, w_now - 1)] < cost_mem[at(idx, w_now - 1)]) idx = r;
			seam_idx[w_now - 1] = idx;
			for (int unsigned c = w_now - 1; c > 0; c--) begin
				vm = (idx > 0) ? cost_mem[at(idx - 1, c - 1)] : 0;
				vp = (idx + 1 < h_now) ? cost_mem[at(idx + 1, c - 1)] : 0;
				idx = pick(idx, h_now - 1, vm, cost_mem[at(idx, c - 1)], vp);
				seam_idx[c - 1] = idx;
			end
			for (int unsigned c = 0; c < w_now; c++)
				for (int unsigned r = seam_idx[c]; r + 1 < h_now; r++)
					pix_mem[at(r, c)] = pix_mem[at(r + 1, c)];
			h_now--;
			seams++;
		endfunction

		function void note_input(logic [1:0] op, logic [7:0] row, logic [7:0] col,
				logic [23:0] rgb);
			pix_result_t res;
			int unsigned tw, th;
			res = '0;
			if (op == OP_WRITE || op == OP_READ) begin
				if (row >= h_now || col >= w_now) res.status = 1'b1;
				else if (op == OP_WRITE) pix_mem[at(row, col)] = rgb;
				else {res.red, res.green, res.blue} = pix_mem[at(row, col)];
			end else if (op == OP_CARVE) begin
				tw = (tgt_w < 2) ? 2 : tgt_w;
				th = (tgt_h < 2) ? 2 : tgt_h;
				while (w_now > tw) cut_vertical();
				while (h_now > th) cut_horizontal();
			end
			res.width = w_now;
			res.height = h_now;
			pending_q.push_back(res);
		endfunction

		function void check(logic [47:0] data, logic [0:0] user);
			pix_result_t e;
			if (pending_q.size() == 0) begin
				$error("result with no request outstanding: tdata=%h", data);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			checked++;
			if (data[7:0] !== e.red) begin
				$error("red_out: expected %0d, got %0d", e.red, data[7:0]);
				errors++;
			end
			if (data[15:8] !== e.green) begin
				$error("green_out: expected %0d, got %0d", e.green, data[15:8]);
				errors++;
			end
			if (data[23:16] !== e.blue) begin
				$error("blue_out: expected %0d, got %0d", e.blue, data[23:16]);
				errors++;
			end
			if (user[0] !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, user[0]);
				errors++;
			end
			if (data[32:24] !== e.width) begin
				$error("current_width: expected %0d, got %0d", e.width, data[32:24]);
				errors++;
			end
			if (data[41:33] !== e.height) begin
				$error("current_height: expected %0d, got %0d", e.height, data[41:33]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = '0;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [0:0]  m_tuser;
	logic [47:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [8:0]  cfg_data = '0;

	pixel_scoreboard sb = new();
	int          hold_off = 0;
	int          items_sent = 0;
	int          carves = 0;

	seam_carving_resizer_top u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: check each accepted result, then choose next ready
	always @(posedge clk) begin : rx_side
		static int stall = 0;
		if (m_tvalid && m_tready) sb.check(m_tdata, m_tuser);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else if (stall > 0) begin
			stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 99) < 25) stall = gap_len();
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_req(logic [1:0] op, logic [7:0] row, logic [7:0] col,
			logic [23:0] rgb, int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tuser <= op;
		s_tdata <= {rgb[7:0], rgb[15:8], rgb[23:16], col, row};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_input(op, row, col, rgb);
		items_sent++;
		if (op == OP_CARVE) carves++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [8:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	task automatic set_sizes(logic [8:0] sw, logic [8:0] sh, logic [8:0] tw, logic [8:0] th);
		drain();
		write_reg(REG_SRC_W, sw);
		write_reg(REG_SRC_H, sh);
		write_reg(REG_TGT_W, tw);
		write_reg(REG_TGT_H, th);
	endtask

	task automatic fill_image();
		for (int r = 0; r < sb.h_now; r++)
			for (int c = 0; c < sb.w_now; c++)
				send_req(OP_WRITE, r, c, $urandom(), gap_len());
	endtask

	// mixed traffic over a fully written image
	task automatic mixed_traffic(int n, bit burst);
		int p, g;
		logic [7:0] r, c;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			g = burst ? 0 : gap_len();
			r = $urandom_range(0, sb.h_now - 1);
			c = $urandom_range(0, sb.w_now - 1);
			if (p < 40) send_req(OP_READ, r, c, $urandom(), g);
			else if (p < 65) send_req(OP_WRITE, r, c, $urandom(), g);
			else if (p < 75) send_req(OP_CARVE, $urandom(), $urandom(), $urandom(), g);
			else if (p < 90) begin
				if ($urandom_range(0, 1)) r = $urandom_range(sb.h_now, 255);
				else c = $urandom_range(sb.w_now, 255);
				send_req($urandom_range(0, 1) ? OP_READ : OP_WRITE, r, c, $urandom(), g);
			end else send_req(2'd3, $urandom(), $urandom(), $urandom(), g);
		end
	endtask

	initial begin : stim
		int sw, sh, phase;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-size corners, unused code, carve with targets already met
		send_req(OP_WRITE, 8'd0, 8'd0, 24'h000000, 0);
		send_req(OP_WRITE, 8'd255, 8'd255, 24'hFFFFFF, 0);
		send_req(OP_WRITE, 8'd0, 8'd255, 24'hA55A0F, 1);
		send_req(OP_READ, 8'd255, 8'd255, 24'h0, 0);
		send_req(OP_READ, 8'd0, 8'd0, 24'hFFFFFF, 2);
		send_req(OP_READ, 8'd0, 8'd255, 24'h0, 0);
		send_req(2'd3, 8'hFF, 8'hFF, 24'hFFFFFF, 0);
		send_req(OP_CARVE, 8'd0, 8'd0, 24'h0, 0);

		// small image; targets below two act as two
		set_sizes(9'd4, 9'd3, 9'd0, 9'd1);
		fill_image();
		send_req(OP_WRITE, 8'd3, 8'd0, 24'h123456, 0);
		send_req(OP_READ, 8'd0, 8'd4, 24'h0, 0);
		send_req(OP_READ, 8'd255, 8'd255, 24'h0, 0);
		send_req(OP_CARVE, 8'd0, 8'd0, 24'h0, 0);
		send_req(OP_READ, 8'd1, 8'd1, 24'h0, 0);
		send_req(OP_READ, 8'd0, 8'd2, 24'h0, 0);

		// widest image, source value above the maximum
		set_sizes(9'd511, 9'd0, 9'd253, 9'd511);
		fill_image();
		mixed_traffic(20, 1'b0);

		phase = 0;
		while (items_sent < 1400) begin
			sw = $urandom_range(2, 7);
			sh = $urandom_range(2, 7);
			set_sizes(sw, sh, ($urandom_range(0, 9) == 0) ? 511 : $urandom_range(0, sw + 1),
				($urandom_range(0, 9) == 0) ? 511 : $urandom_range(0, sh + 1));
			fill_image();
			if (phase == 2) begin
				// result side holds off while requests keep coming
				hold_off = 300;
				mixed_traffic(30, 1'b1);
			end else mixed_traffic($urandom_range(20, 40), 1'b0);
			phase++;
		end
		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d requests (%0d carves, %0d seams removed), %0d results checked",
			items_sent, carves, sb.seams, sb.checked);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#50_000_000;
		$display("FAIL");
		$finish;
	end
endmodule

// ----- seam_carving_resizer_top.f -----
sv/scr_pkg.sv
sv/scr_isqrt.sv
sv/seam_carving_resizer_top.sv
tb/sv/tb_top.sv
